FILE: sv/sensor_reply_decode_store_unit_macros.svh
// Assertion helpers for the block that checks its own control logic.
// The signals clk and rst must be visible where the macros are used.
`ifndef SENSOR_REPLY_DECODE_STORE_UNIT_MACROS_SVH
`define SENSOR_REPLY_DECODE_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold in every cycle outside reset.
`define SRDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define SRDS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define SRDS_ASSERT(label, prop, msg)
`define SRDS_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

FILE: sv/srds_pkg.sv
package srds_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HISTORY_DEPTH = 8;
  localparam int HIST_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Queue between the decoder and the store: depth is a power of two.
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [7:0]  TYPE_U8  = 8'h10;
  localparam logic [7:0]  TYPE_S8  = 8'h11;
  localparam logic [7:0]  TYPE_U16 = 8'h12;
  localparam logic [7:0]  TYPE_S16 = 8'h13;
  localparam logic [7:0]  TYPE_U32 = 8'h14;
  localparam logic [7:0]  TYPE_S32 = 8'h15;
  localparam logic [7:0]  TYPE_F32 = 8'h16;

  localparam logic [15:0] FREE_CHANNEL = 16'hFFFF;

  typedef enum logic [1:0] {
    OUT_OK          = 2'd0,
    OUT_UNSUPPORTED = 2'd1,
    OUT_RANGE       = 2'd2,
    OUT_FAULT       = 2'd3
  } outcome_t;

  // One classified reply as it waits for the store.
  typedef struct packed {
    outcome_t           outcome;
    logic signed [15:0] value;
    logic [15:0]        channel;
    logic [7:0]         status;
    logic [31:0]        stamp;
  } entry_t;

  // One result word.
  typedef struct packed {
    outcome_t           outcome;
    logic signed [15:0] value;
    logic [3:0]         index;
    logic               written;
    logic               enter_error;
    logic               report;
  } result_t;

endpackage

FILE: sv/srds_front.sv
module srds_front
  import srds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [7:0]  s_status,
  input  logic [15:0] s_channel,
  input  logic [7:0]  s_type,
  input  logic [31:0] s_raw,
  input  logic [31:0] s_time,
  output logic        q_push,
  output entry_t      q_entry,
  input  logic        q_full
);

  typedef enum logic [1:0] {F_IDLE, F_SCALE, F_CHECK} fstate_t;
  typedef enum logic [1:0] {K_INT, K_FLOAT, K_UNSUP, K_FAULT} kind_t;

  fstate_t state;

  logic [7:0]  status;
  logic [15:0] channel;
  logic [7:0]  vtype;
  logic [31:0] raw;
  logic [31:0] stamp;

  kind_t              kind;
  logic signed [37:0] prod;
  logic [7:0]         expo;
  logic               sign;
  logic               expo_max;

  // Scale stage: widen the value and multiply by ten with two shifts.
  logic [33:0]        ext;
  logic signed [37:0] ext38;
  logic signed [37:0] prod_int;
  logic [23:0]        mant;
  logic [27:0]        prod_flt;
  kind_t              kind_next;

  always_comb begin
    ext       = '0;
    kind_next = K_INT;
    if (status != 8'd0) begin
      kind_next = K_FAULT;
    end else begin
      case (vtype)
        TYPE_U8:  ext = {26'd0, raw[7:0]};
        TYPE_S8:  ext = {{26{raw[7]}}, raw[7:0]};
        TYPE_U16: ext = {18'd0, raw[15:0]};
        TYPE_S16: ext = {{18{raw[15]}}, raw[15:0]};
        TYPE_U32: ext = {2'd0, raw};
        TYPE_S32: ext = {{2{raw[31]}}, raw};
        TYPE_F32: kind_next = K_FLOAT;
        default:  kind_next = K_UNSUP;
      endcase
    end
    ext38    = {{4{ext[33]}}, ext};
    prod_int = (ext38 <<< 3) + (ext38 <<< 1);
    mant     = (raw[30:23] == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
    prod_flt = 28'({mant, 3'b000}) + 28'({mant, 1'b0});
  end

  // Check stage: shift the float product and test the range.
  logic [7:0]         shamt;
  logic [27:0]        mag;
  entry_t             entry;

  always_comb begin
    shamt         = 8'd150 - expo;
    mag           = (shamt >= 8'd28) ? 28'd0 : (prod[27:0] >> shamt[4:0]);
    entry.channel = channel;
    entry.status  = status;
    entry.stamp   = stamp;
    entry.outcome = OUT_OK;
    entry.value   = '0;
    case (kind)
      K_FAULT: entry.outcome = OUT_FAULT;
      K_UNSUP: entry.outcome = OUT_UNSUPPORTED;
      K_FLOAT: begin
        if (expo_max) begin
          entry.outcome = OUT_RANGE;
        end else if (prod == '0) begin
          entry.outcome = OUT_OK;
        end else if (expo >= 8'd150 || mag > 28'd32767) begin
          entry.outcome = OUT_RANGE;
        end else begin
          entry.value = sign ? -$signed({1'b0, mag[14:0]}) : $signed({1'b0, mag[14:0]});
        end
      end
      default: begin
        if (prod > 38'sd32767 || prod < -38'sd32767) begin
          entry.outcome = OUT_RANGE;
        end else begin
          entry.value = prod[15:0];
        end
      end
    endcase
  end

  assign s_ready = (state == F_IDLE);
  assign q_push  = (state == F_CHECK) && !q_full;
  assign q_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_valid) begin
            status  <= s_status;
            channel <= s_channel;
            vtype   <= s_type;
            raw     <= s_raw;
            stamp   <= s_time;
            state   <= F_SCALE;
          end
        end
        F_SCALE: begin
          kind     <= kind_next;
          prod     <= (kind_next == K_FLOAT) ? $signed({10'd0, prod_flt}) : prod_int;
          expo     <= (raw[30:23] == 8'd0) ? 8'd1 : raw[30:23];
          sign     <= raw[31];
          expo_max <= (raw[30:23] == 8'hFF);
          state    <= F_CHECK;
        end
        F_CHECK: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/srds_queue.sv
module srds_queue
  import srds_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/srds_back.sv
`include "sensor_reply_decode_store_unit_macros.svh"

module srds_back
  import srds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  entry_t  q_head,
  output logic    q_pop,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_result
);

  typedef enum logic [1:0] {B_IDLE, B_WALK, B_DONE} bstate_t;

  bstate_t state;

  logic [15:0]       slot_channel [SLOTS];
  logic [15:0]       slot_value   [SLOTS];
  logic [7:0]        error_history [HISTORY_DEPTH];
  logic [HIST_W-1:0] history_pointer;
  logic [15:0]       fault_channel;
  logic [31:0]       last_fault_time;
  logic              report_flag;

  logic [SLOT_W-1:0] walk;
  result_t           pend;
  result_t           res;
  result_t           res_next;
  logic              res_valid;

  logic hit;
  logic finish;
  logic fault;

  assign hit    = (slot_channel[walk] == FREE_CHANNEL) || (slot_channel[walk] == q_head.channel);
  assign finish = (state == B_DONE) && (!res_valid || m_ready);
  assign fault  = (pend.outcome == OUT_FAULT);
  assign q_pop  = finish;

  assign m_valid  = res_valid;
  assign m_result = res;

  // The result word carries the report flag as it stands after this reply.
  always_comb begin
    res_next        = pend;
    res_next.report = report_flag | fault;
  end

  always_ff @(posedge clk) begin
    if (state == B_WALK && hit) begin
      slot_value[walk] <= q_head.value;
    end
    if (finish && fault) begin
      error_history[history_pointer] <= q_head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_IDLE;
      res_valid       <= 1'b0;
      report_flag     <= 1'b0;
      history_pointer <= '0;
      fault_channel   <= '0;
      last_fault_time <= '0;
      walk            <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_channel[i] <= FREE_CHANNEL;
      end
    end else begin
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_valid && m_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            pend.outcome     <= q_head.outcome;
            pend.value       <= q_head.value;
            pend.index       <= '0;
            pend.written     <= 1'b0;
            pend.enter_error <= (q_head.outcome != OUT_OK);
            pend.report      <= 1'b0;
            walk             <= '0;
            state            <= (q_head.outcome == OUT_OK) ? B_WALK : B_DONE;
          end
        end
        B_WALK: begin
          if (hit) begin
            slot_channel[walk] <= q_head.channel;
            pend.index         <= 4'(walk);
            pend.written       <= 1'b1;
            state              <= B_DONE;
          end else if (walk == SLOT_W'(SLOTS - 1)) begin
            state <= B_DONE;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        B_DONE: begin
          if (finish) begin
            res   <= res_next;
            state <= B_IDLE;
            if (fault) begin
              report_flag     <= 1'b1;
              fault_channel   <= q_head.channel;
              last_fault_time <= q_head.stamp;
              history_pointer <= (history_pointer == HIST_W'(HISTORY_DEPTH - 1)) ?
                                 '0 : history_pointer + 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `SRDS_ASSERT(a_walk_has_head, (state != B_WALK) || !q_empty, "slot walk without a queued reply")
  `SRDS_ASSERT(a_fail_clean, !res_valid || res.outcome == OUT_OK || (res.value == 16'sd0 && !res.written), "failed result carries a value or a slot")
  `SRDS_ASSERT(a_error_flag, !res_valid || (res.enter_error == (res.outcome != OUT_OK)), "error flag disagrees with outcome")
  `SRDS_ASSERT_NEXT(a_report_sticky, report_flag, report_flag, "report flag cleared outside reset")
  `SRDS_ASSERT(a_fault_reports, !res_valid || res.outcome != OUT_FAULT || res.report, "fault result without report request")

endmodule

FILE: sv/sensor_reply_decode_store_unit.sv
// Sensor reply decoder and channel value store. Each input word is one decoded
// sensor reply; each reply gives exactly one result word, in order. With a zero
// status the raw value is decoded by its type code (unsigned or signed 8, 16 or
// 32 bit, or IEEE single), scaled exactly to tenths (floats truncate toward
// zero) and checked against -32767..32767; a good value is written to the first
// of the sixteen channel slots that is free or already holds the channel, and a
// full table drops it with slot_written low. A nonzero status records the fault
// channel and time, pushes the status onto the error ring and raises the sticky
// report flag, which only reset clears. The decoder takes one reply at a time
// (capture, multiply by ten, shift and range check), waits while the queue is
// full, and hands it to a two-entry queue; the store finishes a fault or a
// rejected value without a walk and walks the table for a good one, one slot
// a cycle. The result sits in an output register, so the decoder keeps taking
// replies while a result waits to be taken, until the queue fills.
module sensor_reply_decode_store_unit
  import srds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] status_code, [23:8] channel, [55:24] value_bytes, [87:56] now_time
  input  logic [87:0] s_axis_tdata,
  // [7:0] value_type
  input  logic [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] scaled_value, [19:16] slot_index, [20] slot_written,
  // [21] enter_error, [22] report_pending, [23] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] outcome
  output logic [1:0]  m_axis_tuser
);

  // Decoder to queue, and queue to store.
  logic    q_push;
  entry_t  q_in;
  logic    q_full;
  logic    q_pop;
  entry_t  q_head;
  logic    q_empty;
  result_t result;

  srds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_status  (s_axis_tdata[7:0]),
    .s_channel (s_axis_tdata[23:8]),
    .s_type    (s_axis_tuser),
    .s_raw     (s_axis_tdata[55:24]),
    .s_time    (s_axis_tdata[87:56]),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_full    (q_full)
  );

  srds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  srds_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_result (result)
  );

  // Result word packing, highest field first.
  assign m_axis_tdata = {1'b0, result.report, result.enter_error, result.written,
                         result.index, result.value};
  assign m_axis_tuser = result.outcome;

endmodule
